>>> src/voxel_grid_ray_traversal_macros.svh
// ----------------------------------------------------------------------------
// voxel grid ray traversal assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_MACROS_SVH

// same-cycle implication
`define VGRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VGRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vgrt_pkg.sv
// ----------------------------------------------------------------------------
// vgrt_pkg
// types, constants and helpers shared by the voxel grid ray traversal block
// ----------------------------------------------------------------------------
package vgrt_pkg;

    localparam int MAX_CELLS = 16;

    // divider operand kinds
    localparam logic [1:0] DK_IDX = 2'd0;
    localparam logic [1:0] DK_TN  = 2'd1;
    localparam logic [1:0] DK_TD  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_X = 3'd0;
    localparam logic [2:0] CFG_MIN_Y = 3'd1;
    localparam logic [2:0] CFG_MIN_Z = 3'd2;
    localparam logic [2:0] CFG_EDGE  = 3'd3;
    localparam logic [2:0] CFG_CNT_X = 3'd4;
    localparam logic [2:0] CFG_CNT_Y = 3'd5;
    localparam logic [2:0] CFG_CNT_Z = 3'd6;

    localparam logic [5:0]  LAST_K = 6'd63;
    localparam logic [31:0] TSAT   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       load;
        logic       clr_out;
        logic       div_start;
        logic [1:0] div_kind;
        logic [1:0] div_axis;
        logic [1:0] axis;
        logic       cap_idx;
        logic       set_sign;
        logic       zero_axis;
        logic       cap_tn;
        logic       cap_td;
        logic       step;
    } cmd_t;

    typedef struct packed {
        logic outside;
        logic dir_zero;
        logic div_done;
        logic done;
    } stat_t;

    function automatic logic [4:0] cnt_eff(input logic [4:0] c);
        logic [4:0] r;
        r = c;
        if (c == 5'd0) r = 5'd1;
        else if (c > 5'(MAX_CELLS)) r = 5'(MAX_CELLS);
        return r;
    endfunction

endpackage

>>> src/voxel_grid_ray_traversal.sv
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal
// 3d dda walk of a uniform voxel grid, one request is one ray
// ----------------------------------------------------------------------------
// A ray is taken when the block is idle. Setup runs the range check, then per
// axis a division for the start index and a setup step, and for an axis with
// nonzero direction two more divisions, all on the shared bit-serial divider.
// After that one cell is emitted per cycle while out_stall is low, the last
// one flagged. A ray whose origin lies outside the grid gives a single result
// with origin_inside low, from the output state that follows the range check.
module voxel_grid_ray_traversal
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         cell_x,
    output logic [3:0]         cell_y,
    output logic [3:0]         cell_z,
    output logic               origin_inside,
    output logic               last
);

`include "voxel_grid_ray_traversal_macros.svh"

    vgrt_pkg::cmd_t  cmd;
    vgrt_pkg::stat_t stat;

    vgrt_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .origin_inside (origin_inside),
        .last          (last),
        .stat          (stat),
        .cmd           (cmd)
    );

    vgrt_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .cmd       (cmd),
        .stat      (stat),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .cell_z    (cell_z)
    );

    `VGRT_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "ray taken but still ready")
    `VGRT_ASSERT_NOW(a_outside_is_last, out_valid && !origin_inside, last, "outside result not last")
    `VGRT_ASSERT_NOW(a_no_take_while_out, out_valid, in_stall, "ray taken during emission")
    `VGRT_ASSERT_NEXT(a_idle_after_last, out_valid && !out_stall && last, !out_valid, "result after last")

endmodule

>>> src/vgrt_div.sv
// ----------------------------------------------------------------------------
// vgrt_div
// restoring divider, 48 bit dividend by 32 bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module vgrt_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [31:0] den,
    output logic [47:0] quot,
    output logic        done
);

    logic [47:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[47]};
        if (start)
        begin
            q_next    = num;
            r_next    = 32'd0;
            d_next    = den;
            n_next    = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 32'(trial - {1'b0, d_reg});
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_next = trial[31:0];
                q_next = {q_reg[46:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            n_reg    <= n_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

>>> src/vgrt_dp.sv
// ----------------------------------------------------------------------------
// vgrt_dp
// datapath: configuration, ray setup arithmetic and cell stepping
// ----------------------------------------------------------------------------
module vgrt_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [31:0]  origin_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  vgrt_pkg::cmd_t      cmd,
    output vgrt_pkg::stat_t     stat,
    output logic [3:0]          cell_x,
    output logic [3:0]          cell_y,
    output logic [3:0]          cell_z
);

    logic [31:0] gmin_reg [3];
    logic [30:0] edge_reg;
    logic [4:0]  cnt_reg [3];

    logic [32:0] diff_reg [3];
    logic [31:0] dir_reg [3];
    logic [4:0]  pos_reg [3];
    logic [5:0]  sign_reg;
    logic [31:0] tn_reg [3];
    logic [31:0] td_reg [3];
    logic [5:0]  k_reg;

    logic [31:0] org [3];
    logic [31:0] dirin [3];
    logic [30:0] edge_eff;
    logic [4:0]  cnt [3];
    logic [35:0] lim [3];
    logic [2:0]  over;
    logic [1:0]  ax;
    logic [1:0]  dax;
    logic [35:0] lo;
    logic signed [37:0] dpos, dneg, dsel;
    logic [31:0] gap;
    logic [31:0] mag;
    logic [47:0] dnum;
    logic [31:0] dden;
    logic [47:0] quot;
    logic        ddone;
    logic [4:0]  qidx;
    logic [31:0] qsat;
    logic [32:0] key [3];
    logic [1:0]  sel;
    logic        mv, ng;
    logic [5:0]  pos_inc;
    logic [32:0] tsum;

    assign org[0]   = origin_x;
    assign org[1]   = origin_y;
    assign org[2]   = origin_z;
    assign dirin[0] = dir_x;
    assign dirin[1] = dir_y;
    assign dirin[2] = dir_z;

    assign edge_eff = (edge_reg == 31'd0) ? 31'd1 : edge_reg;
    assign ax       = cmd.axis;
    assign dax      = cmd.div_axis;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cnt[a]  = vgrt_pkg::cnt_eff(cnt_reg[a]);
            lim[a]  = 36'(cnt[a]) * 36'(edge_eff);
            over[a] = diff_reg[a][32] ||
                      ($signed({{4{diff_reg[a][32]}}, diff_reg[a]}) >
                       $signed({1'b0, lim[a]}));
        end
    end

    // setup arithmetic for the axis the divider starts on
    always_comb
    begin
        lo   = 36'(pos_reg[dax]) * 36'(edge_eff);
        dpos = $signed({2'b00, lo}) + $signed({7'd0, edge_eff})
               - $signed({{5{diff_reg[dax][32]}}, diff_reg[dax]});
        dneg = $signed({{5{diff_reg[dax][32]}}, diff_reg[dax]}) - $signed({2'b00, lo});
        dsel = dir_reg[dax][31] ? dneg : dpos;
        gap  = dsel[37] ? 32'd0 : dsel[31:0];
        mag  = dir_reg[dax][31] ? (~dir_reg[dax] + 32'd1) : dir_reg[dax];
        case (cmd.div_kind)
            vgrt_pkg::DK_IDX:
            begin
                dnum = {15'd0, diff_reg[dax]};
                dden = {1'b0, edge_eff};
            end
            vgrt_pkg::DK_TN:
            begin
                dnum = {gap, 16'd0};
                dden = mag;
            end
            default:
            begin
                dnum = {1'b0, edge_eff, 16'd0};
                dden = mag;
            end
        endcase
    end

    vgrt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dnum),
        .den   (dden),
        .quot  (quot),
        .done  (ddone)
    );

    assign qidx = (quot > 48'(cnt[ax] - 5'd1)) ? (cnt[ax] - 5'd1) : quot[4:0];
    assign qsat = (quot[47:32] != 16'd0) ? vgrt_pkg::TSAT : quot[31:0];

    // axis choice for the next step, ties go x then y then z
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            key[a] = sign_reg[2*a] ? {1'b0, tn_reg[a]} : 33'h1_0000_0000;
        if (key[0] <= key[1] && key[0] <= key[2]) sel = 2'd0;
        else if (key[1] <= key[2]) sel = 2'd1;
        else sel = 2'd2;
        mv      = sign_reg[{sel, 1'b0}];
        ng      = sign_reg[{sel, 1'b1}];
        pos_inc = {1'b0, pos_reg[sel]} + 6'd1;
        tsum    = {1'b0, tn_reg[sel]} + {1'b0, td_reg[sel]};
    end

    assign stat.outside  = |over;
    assign stat.dir_zero = (dir_reg[ax] == 32'd0);
    assign stat.div_done = ddone;
    assign stat.done     = !mv || (ng && pos_reg[sel] == 5'd0) ||
                           (!ng && pos_inc >= {1'b0, cnt[sel]}) ||
                           (k_reg == vgrt_pkg::LAST_K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                gmin_reg[a] <= 32'd0;
                cnt_reg[a]  <= 5'd16;
                pos_reg[a]  <= 5'd0;
                tn_reg[a]   <= 32'd0;
                td_reg[a]   <= 32'd0;
            end
            edge_reg <= 31'd65536;
            sign_reg <= 6'd0;
            k_reg    <= 6'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vgrt_pkg::CFG_MIN_X: gmin_reg[0] <= cfg_data;
                    vgrt_pkg::CFG_MIN_Y: gmin_reg[1] <= cfg_data;
                    vgrt_pkg::CFG_MIN_Z: gmin_reg[2] <= cfg_data;
                    vgrt_pkg::CFG_EDGE:  edge_reg    <= cfg_data[30:0];
                    vgrt_pkg::CFG_CNT_X: cnt_reg[0]  <= cfg_data[4:0];
                    vgrt_pkg::CFG_CNT_Y: cnt_reg[1]  <= cfg_data[4:0];
                    vgrt_pkg::CFG_CNT_Z: cnt_reg[2]  <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                sign_reg <= 6'd0;
                k_reg    <= 6'd0;
            end
            if (cmd.clr_out)
                for (int a = 0; a < 3; a++)
                    pos_reg[a] <= 5'd0;
            if (cmd.cap_idx)
                pos_reg[ax] <= qidx;
            if (cmd.set_sign)
                sign_reg[{ax, 1'b0} +: 2] <= {dir_reg[ax][31], 1'b1};
            if (cmd.zero_axis)
            begin
                tn_reg[ax] <= vgrt_pkg::TSAT;
                td_reg[ax] <= vgrt_pkg::TSAT;
            end
            if (cmd.cap_tn)
                tn_reg[ax] <= qsat;
            if (cmd.cap_td)
                td_reg[ax] <= qsat;
            if (cmd.step)
            begin
                k_reg        <= k_reg + 6'd1;
                pos_reg[sel] <= ng ? (pos_reg[sel] - 5'd1) : pos_inc[4:0];
                tn_reg[sel]  <= tsum[32] ? vgrt_pkg::TSAT : tsum[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= {org[a][31], org[a]} - {gmin_reg[a][31], gmin_reg[a]};
                dir_reg[a]  <= dirin[a];
            end
    end

    assign cell_x = pos_reg[0][3:0];
    assign cell_y = pos_reg[1][3:0];
    assign cell_z = pos_reg[2][3:0];

endmodule

>>> src/vgrt_ctrl.sv
// ----------------------------------------------------------------------------
// vgrt_ctrl
// sequencer: ray accept, per-axis setup divisions, cell emission
// ----------------------------------------------------------------------------
module vgrt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            origin_inside,
    output logic            last,
    input  vgrt_pkg::stat_t stat,
    output vgrt_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_IDX   = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_TN    = 3'd4;
    localparam logic [2:0] S_TD    = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       take;

    assign take = !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.axis     = axis_reg;
        cmd.div_axis = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                axis_next = 2'd0;
                if (stat.outside)
                begin
                    cmd.clr_out = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.div_axis  = 2'd0;
                    cmd.div_start = 1'b1;
                    cmd.div_kind  = vgrt_pkg::DK_IDX;
                    state_next    = S_IDX;
                end
            end
            S_IDX:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_idx = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (stat.dir_zero)
                begin
                    cmd.zero_axis = 1'b1;
                    if (axis_reg == 2'd2)
                        state_next = S_EMIT;
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                        state_next = S_SETUP;
                        cmd.div_start = 1'b1;
                        cmd.div_kind  = vgrt_pkg::DK_IDX;
                        cmd.div_axis  = axis_reg + 2'd1;
                        state_next    = S_IDX;
                    end
                end
                else
                begin
                    cmd.set_sign  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_kind  = vgrt_pkg::DK_TN;
                    state_next    = S_TN;
                end
            end
            S_TN:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_tn    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_kind  = vgrt_pkg::DK_TD;
                    state_next    = S_TD;
                end
            end
            S_TD:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_td = 1'b1;
                    if (axis_reg == 2'd2)
                        state_next = S_EMIT;
                    else
                    begin
                        axis_next     = axis_reg + 2'd1;
                        cmd.div_start = 1'b1;
                        cmd.div_kind  = vgrt_pkg::DK_IDX;
                        cmd.div_axis  = axis_reg + 2'd1;
                        state_next    = S_IDX;
                    end
                end
            end
            S_EMIT:
            begin
                if (take)
                begin
                    if (stat.done)
                        state_next = S_IDLE;
                    else
                        cmd.step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the divider starts on the axis it will work on next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_EMIT) || (state_reg == S_OUT);
    assign origin_inside = (state_reg == S_EMIT);
    assign last          = (state_reg == S_OUT) || stat.done;

endmodule

>>> tb/voxel_grid_ray_traversal_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel grid ray traversal checker
// watches the configuration port and both channels, predicts the cell walk of
// every accepted request and compares each emitted cell with the oldest one
// ----------------------------------------------------------------------------
module voxel_grid_ray_traversal_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         cell_x,
    input  logic [3:0]         cell_y,
    input  logic [3:0]         cell_z,
    input  logic               origin_inside,
    input  logic               last,
    output int                 pending,
    output int                 errors
);

    typedef struct packed {
        logic [3:0] cx;
        logic [3:0] cy;
        logic [3:0] cz;
        logic       in_grid;
        logic       fin;
    } cell_t;

    cell_t             cells_due[$];
    logic signed [31:0] gmin [3];
    logic [30:0]        edge_len;
    logic [4:0]         cnt [3];

    assign pending = cells_due.size();

    function automatic longint count_of(logic [4:0] c);
        longint r;
        r = c;
        if (c == 5'd0) r = 1;
        else if (c > 5'(vgrt_pkg::MAX_CELLS)) r = vgrt_pkg::MAX_CELLS;
        return r;
    endfunction

    function automatic longint quot_sat(longint num, longint den);
        longint q;
        q = (num << 16) / den;
        return (q > longint'(vgrt_pkg::TSAT)) ? longint'(vgrt_pkg::TSAT) : q;
    endfunction

    function automatic void queue_cell(cell_t c);
        cells_due.insert(cells_due.size(), c);
    endfunction

    function automatic void walk_ray(logic signed [31:0] org [3], logic signed [31:0] dir [3]);
        longint e, d [3], p [3], tn [3], td [3], idx, lo, gap, mag, key, best, s;
        logic mv [3], ng [3];
        logic outside, done;
        int a, ax, k;
        cell_t c;
        e = (edge_len == 0) ? 1 : longint'(edge_len);
        outside = 0;
        for (a = 0; a < 3; a++)
        begin
            d[a] = longint'(org[a]) - longint'(gmin[a]);
            if (d[a] < 0 || d[a] > count_of(cnt[a]) * e) outside = 1;
        end
        if (outside)
        begin
            c = '{4'd0, 4'd0, 4'd0, 1'b0, 1'b1};
            queue_cell(c);
            return;
        end
        for (a = 0; a < 3; a++)
        begin
            idx = d[a] / e;
            if (idx > count_of(cnt[a]) - 1) idx = count_of(cnt[a]) - 1;
            p[a] = idx;
            lo = idx * e;
            mv[a] = (dir[a] != 0);
            ng[a] = (dir[a] < 0);
            if (!mv[a])
            begin
                tn[a] = longint'(vgrt_pkg::TSAT);
                td[a] = longint'(vgrt_pkg::TSAT);
            end
            else
            begin
                gap = ng[a] ? d[a] - lo : lo + e - d[a];
                mag = ng[a] ? -longint'(dir[a]) : longint'(dir[a]);
                if (gap < 0) gap = 0;
                tn[a] = quot_sat(gap, mag);
                td[a] = quot_sat(e, mag);
            end
        end
        k = 0;
        forever
        begin
            c = '{p[0][3:0], p[1][3:0], p[2][3:0], 1'b1, 1'b0};
            queue_cell(c);
            k++;
            ax = 0;
            best = mv[0] ? tn[0] : 64'h1_0000_0000;
            for (a = 1; a < 3; a++)
            begin
                key = mv[a] ? tn[a] : 64'h1_0000_0000;
                if (key < best)
                begin
                    best = key;
                    ax = a;
                end
            end
            done = 0;
            if (!mv[ax]) done = 1;
            else if (ng[ax])
            begin
                if (p[ax] == 0) done = 1;
                else p[ax]--;
            end
            else
            begin
                if (p[ax] + 1 >= count_of(cnt[ax])) done = 1;
                else p[ax]++;
            end
            if (done || k >= 64) break;
            s = tn[ax] + td[ax];
            tn[ax] = (s > longint'(vgrt_pkg::TSAT)) ? longint'(vgrt_pkg::TSAT) : s;
        end
        cells_due[cells_due.size() - 1].fin = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_t want, got;
        logic signed [31:0] o [3], v [3];
        if (!rst_n)
        begin
            gmin[0] = 0;
            gmin[1] = 0;
            gmin[2] = 0;
            edge_len = 31'd65536;
            cnt[0] = 5'd16;
            cnt[1] = 5'd16;
            cnt[2] = 5'd16;
            errors = 0;
            cells_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vgrt_pkg::CFG_MIN_X: gmin[0] = cfg_data;
                    vgrt_pkg::CFG_MIN_Y: gmin[1] = cfg_data;
                    vgrt_pkg::CFG_MIN_Z: gmin[2] = cfg_data;
                    vgrt_pkg::CFG_EDGE:  edge_len = cfg_data[30:0];
                    vgrt_pkg::CFG_CNT_X: cnt[0] = cfg_data[4:0];
                    vgrt_pkg::CFG_CNT_Y: cnt[1] = cfg_data[4:0];
                    vgrt_pkg::CFG_CNT_Z: cnt[2] = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                o[0] = origin_x;
                o[1] = origin_y;
                o[2] = origin_z;
                v[0] = dir_x;
                v[1] = dir_y;
                v[2] = dir_z;
                walk_ray(o, v);
            end
            if (out_valid && !out_stall)
            begin
                got = '{cell_x, cell_y, cell_z, origin_inside, last};
                if (cells_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected cell, expected none, actual %h", $realtime, got);
                end
                else
                begin
                    want = cells_due.pop_front();
                    if (got.cx !== want.cx)
                    begin
                        errors++;
                        $display("%0t: cell_x expected %0d actual %0d", $realtime, want.cx, got.cx);
                    end
                    if (got.cy !== want.cy)
                    begin
                        errors++;
                        $display("%0t: cell_y expected %0d actual %0d", $realtime, want.cy, got.cy);
                    end
                    if (got.cz !== want.cz)
                    begin
                        errors++;
                        $display("%0t: cell_z expected %0d actual %0d", $realtime, want.cz, got.cz);
                    end
                    if (got.in_grid !== want.in_grid)
                    begin
                        errors++;
                        $display("%0t: origin_inside expected %0b actual %0b", $realtime,
                                 want.in_grid, got.in_grid);
                    end
                    if (got.fin !== want.fin)
                    begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b", $realtime, want.fin, got.fin);
                    end
                end
            end
        end
    end

endmodule

>>> tb/voxel_grid_ray_traversal_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel grid ray traversal test
// directed and random rays over several grid settings, random idling on both
// channels, results checked cell by cell by the checker module
// ----------------------------------------------------------------------------
module voxel_grid_ray_traversal_test;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = vgrt_pkg::CFG_MIN_X;
    logic [31:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
    logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [3:0]         cell_x, cell_y, cell_z;
    logic               origin_inside, last;
    int                 pending, errors;

    int                 idle_pct = 8;
    logic signed [31:0] gmin [3];
    longint             edge_eff;
    longint             cnt_eff3 [3];

    voxel_grid_ray_traversal dut (.*);
    voxel_grid_ray_traversal_check check (.*);

    always #2 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    initial
    begin
        #8_000_000;
        $display("[voxel_grid_ray_traversal] ERROR");
        $finish;
    end

    task automatic send_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        origin_x <= ox;
        origin_y <= oy;
        origin_z <= oz;
        dir_x <= dx;
        dir_y <= dy;
        dir_z <= dz;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_grid(logic [31:0] mx, my, mz, logic [31:0] e, logic [4:0] nx, ny, nz);
        logic [31:0] vals [7];
        int i;
        vals = '{mx, my, mz, e, 32'(nx), 32'(ny), 32'(nz)};
        for (i = 0; i < 7; i++)
        begin
            cfg_we <= 1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 0;
        gmin = '{mx, my, mz};
        edge_eff = (e[30:0] == 0) ? 1 : longint'(e[30:0]);
        cnt_eff3[0] = (nx == 0) ? 1 : (nx > 16) ? 16 : nx;
        cnt_eff3[1] = (ny == 0) ? 1 : (ny > 16) ? 16 : ny;
        cnt_eff3[2] = (nz == 0) ? 1 : (nz > 16) ? 16 : nz;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_origin(int a);
        longint span, off;
        span = cnt_eff3[a] * edge_eff;
        off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (span + 1);
        case ($urandom_range(9))
            0: off = 0;
            1: off = span;
            2: off = (off / edge_eff) * edge_eff;
            default: ;
        endcase
        return 32'(longint'(gmin[a]) + off);
    endfunction

    function automatic logic signed [31:0] pick_dir();
        case ($urandom_range(9))
            0, 1: return 0;
            2, 3: return $urandom;
            4: return $urandom_range(1, 3) * (($urandom_range(1)) ? 1 : -1);
            5: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
        endcase
    endfunction

    task automatic random_rays(int n);
        int i;
        logic signed [31:0] d;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                d = pick_dir();
                if ($urandom_range(4) == 0)
                    send_ray(pick_origin(0), pick_origin(1), pick_origin(2), d, d, d);
                else
                    send_ray(pick_origin(0), pick_origin(1), pick_origin(2),
                             pick_dir(), pick_dir(), pick_dir());
            end
        end
    endtask

    initial
    begin
        int p;
        gmin = '{0, 0, 0};
        edge_eff = 65536;
        cnt_eff3 = '{16, 16, 16};
        repeat (9) @(posedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed rays on the reset grid
        send_ray(32'h0008_8000, 32'h0008_8000, 32'h0008_8000, 32'h0001_0000, 0, 0);
        send_ray(32'h0008_8000, 32'h0008_8000, 32'h0008_8000, -32'sh0001_0000, 0, 0);
        send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 32'h0001_0000, 0);
        send_ray(32'h000F_8000, 32'h000F_8000, 32'h000F_8000, 0, 0, -32'sh0001_0000);
        send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_ray(0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_ray(32'h0003_0000, 32'h0005_0000, 32'h0007_0000, 0, 0, 0);
        send_ray(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, -32'sh1_0000, 0, 0);
        send_ray(32'h0010_0000, 32'h0004_0000, 32'h0004_0000, 32'h1_0000, 0, 0);
        send_ray(-32'sh1, 32'h0004_0000, 32'h0004_0000, 32'h1_0000, 0, 0);
        send_ray(32'h0004_0000, 32'h0010_0001, 32'h0004_0000, 32'h1_0000, 0, 0);
        send_ray(32'h0004_0000, 32'h0004_0000, 32'sh8000_0000, 32'h1_0000, 0, 0);
        send_ray(32'h0004_0000, 32'h0004_0000, 32'sh7FFF_FFFF, 32'h1_0000, 0, 0);
        send_ray(32'h0000_8000, 32'h0008_8000, 32'h0008_8000, 1, -1, 32'sh8000_0000);
        send_ray(32'h0008_8000, 32'h0008_8000, 32'h0008_8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        send_ray(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h3_0000, 32'h2_0000, 32'h1_0000);
        send_ray(32'h0004_4000, 32'h0007_C000, 32'h0001_2000, -32'sh1234, 32'h5678, -32'sh9ABC);

        // pause the sender until every cell is back
        drain();

        for (p = 0; p < 7; p++)
        begin
            case (p)
                0: set_grid(0, 0, 0, 32'h0001_0000, 5'd16, 5'd16, 5'd16);
                1: set_grid(32'h8000_0000, 32'h7FFF_FFF0, 32'hFFFF_FFFF, 32'd1, 5'd16, 5'd1, 5'd8);
                2: set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            5'd1, 5'd1, 5'd1);
                3: set_grid($urandom, $urandom, $urandom, 32'h8000_0000, 5'd0, 5'd31, 5'd17);
                4: set_grid(32'hFFF8_0000, 32'h0000_1234, 32'hFFFF_0000, 32'h0000_4000,
                            5'd3, 5'd16, 5'd2);
                5: set_grid($urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFFFF), 0,
                            $urandom_range(32'h1000, 32'h10_0000), 5'($urandom_range(1, 16)),
                            5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)));
                default: set_grid(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
                                  5'd16, 5'd16, 5'd16);
            endcase
            if (p == 4) idle_pct = 0;
            random_rays(60);
            idle_pct = 8;
            drain();
        end

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("[voxel_grid_ray_traversal] OK");
        else
            $display("[voxel_grid_ray_traversal] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/vgrt_pkg.sv
src/vgrt_div.sv
src/vgrt_dp.sv
src/vgrt_ctrl.sv
src/voxel_grid_ray_traversal.sv
tb/voxel_grid_ray_traversal_check.sv
tb/voxel_grid_ray_traversal_test.sv
